// ----- hdl/swdr_pkg.sv -----
// Shared types, constants and width helpers for the signed window digit recoder.
package swdr_pkg;

  localparam int unsigned ScalarBits = 128;
  localparam int unsigned HalfBits   = 64;
  localparam int unsigned WidthBits  = 5;
  localparam int unsigned IdxBits    = 4;
  localparam int unsigned MagBits    = 17;
  localparam int unsigned WinMaxBits = 16;

  localparam logic [WidthBits-1:0] WidthW10 = 5'd10;
  localparam logic [WidthBits-1:0] WidthW11 = 5'd11;
  localparam logic [WidthBits-1:0] WidthW12 = 5'd12;
  localparam logic [WidthBits-1:0] WidthW13 = 5'd13;
  localparam logic [WidthBits-1:0] WidthW14 = 5'd14;
  localparam logic [WidthBits-1:0] WidthW15 = 5'd15;
  localparam logic [WidthBits-1:0] WidthW16 = 5'd16;
  localparam logic [WidthBits-1:0] WidthReset = WidthW16;

  // Register indexes on the configuration port
  localparam logic RegWindowWidth = 1'b0;

  typedef struct packed {
    logic [HalfBits-1:0] scalar_low;
    logic [HalfBits-1:0] scalar_high;
  } in_t;

  typedef struct packed {
    logic [IdxBits-1:0] window_index;
    logic               digit_negative;
    logic [MagBits-1:0] digit_magnitude;
    logic               last_digit;
  } out_t;

  // One queued scalar with its classification
  typedef struct packed {
    logic [ScalarBits-1:0] scalar;
    logic [WidthBits-1:0]  wsel;
    logic [IdxBits-1:0]    last_idx;
  } job_t;

  function automatic logic [WidthBits-1:0] eff_width(input logic [WidthBits-1:0] req);
    logic [WidthBits-1:0] w;
    priority if (req <= WidthW10) w = WidthW10;
    else if (req == WidthW11) w = WidthW11;
    else if (req == WidthW12) w = WidthW12;
    else if (req == WidthW13 || req == WidthW14) w = WidthW13;
    else if (req == WidthW15) w = WidthW15;
    else w = WidthW16;
    return w;
  endfunction

  // Index of the top window for an effective width
  function automatic logic [IdxBits-1:0] top_index(input logic [WidthBits-1:0] w);
    logic [IdxBits-1:0] n;
    unique case (w)
      WidthW10: n = 4'd12;
      WidthW11: n = 4'd11;
      WidthW12: n = 4'd10;
      WidthW13: n = 4'd9;
      WidthW15: n = 4'd8;
      default:  n = 4'd7;
    endcase
    return n;
  endfunction

endpackage

// ----- hdl/swdr_front.sv -----
// Front end: configuration register, input acceptance and width classification.
module swdr_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  swdr_pkg::in_t                     in_data_i,
  output logic                              push_o,
  output swdr_pkg::job_t                    push_data_o,
  input  logic                              q_ready_i
);

  logic [swdr_pkg::WidthBits-1:0] width_q;
  logic [swdr_pkg::WidthBits-1:0] eff_w;
  logic                           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == swdr_pkg::RegWindowWidth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= swdr_pkg::WidthReset;
    end else if (wr_en) begin
      width_q <= pwdata[swdr_pkg::WidthBits-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == swdr_pkg::RegWindowWidth) begin
      prdata = {{(32-swdr_pkg::WidthBits){1'b0}}, width_q};
    end
  end

  assign eff_w      = swdr_pkg::eff_width(width_q);
  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

  assign push_data_o.scalar   = {in_data_i.scalar_high, in_data_i.scalar_low};
  assign push_data_o.wsel     = eff_w;
  assign push_data_o.last_idx = swdr_pkg::top_index(eff_w);

endmodule

// ----- hdl/swdr_queue.sv -----
// Two-entry queue between the front end and the digit generator.
module swdr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  swdr_pkg::job_t push_data_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output swdr_pkg::job_t pop_data_o
);

  swdr_pkg::job_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;

  assign ready_o    = (cnt_q != 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != 2'd2 || pop_i)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 2'd0)
    else $error("queue pop while empty");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue count out of range");

endmodule

// ----- hdl/swdr_back.sv -----
// Back end: registers one digit per unstalled cycle, walking the held scalar.
module swdr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  swdr_pkg::job_t q_data_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output swdr_pkg::out_t out_data_o
);

  logic                               busy_q;
  logic [swdr_pkg::ScalarBits-1:0]    sh_q;
  logic [swdr_pkg::IdxBits-1:0]       cnt_q, last_idx_q;
  logic                               carry_q;
  logic [swdr_pkg::WidthBits-1:0]     wsel_q;
  logic                               out_valid_q;
  swdr_pkg::out_t                     out_q;

  logic                               adv, is_last, carry_nx, neg;
  logic [swdr_pkg::MagBits-1:0]       full, half, mask, v, mag;
  logic [swdr_pkg::WinMaxBits-1:0]    win;
  logic [swdr_pkg::ScalarBits-1:0]    sh_nx;

  assign adv     = busy_q && (!out_valid_q || out_ready_i);
  assign is_last = (cnt_q == last_idx_q);
  assign pop_o   = q_valid_i && (!busy_q || (adv && is_last));

  always_comb begin
    full     = swdr_pkg::MagBits'(1) << wsel_q;
    half     = full >> 1;
    mask     = full - swdr_pkg::MagBits'(1);
    // top window keeps every remaining bit, zeros above came from the shifts
    win      = is_last ? sh_q[swdr_pkg::WinMaxBits-1:0]
                       : (sh_q[swdr_pkg::WinMaxBits-1:0] & mask[swdr_pkg::WinMaxBits-1:0]);
    v        = {1'b0, win} + swdr_pkg::MagBits'(carry_q);
    carry_nx = 1'b0;
    neg      = 1'b0;
    mag      = v;
    if (!is_last && (v > half)) begin
      carry_nx = 1'b1;
      if (v == full) begin
        mag = '0;
      end else begin
        neg = 1'b1;
        mag = full - v;
      end
    end
  end

  always_comb begin
    unique case (wsel_q)
      swdr_pkg::WidthW10: sh_nx = sh_q >> 10;
      swdr_pkg::WidthW11: sh_nx = sh_q >> 11;
      swdr_pkg::WidthW12: sh_nx = sh_q >> 12;
      swdr_pkg::WidthW13: sh_nx = sh_q >> 13;
      swdr_pkg::WidthW15: sh_nx = sh_q >> 15;
      default:            sh_nx = sh_q >> 16;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      carry_q     <= 1'b0;
      wsel_q      <= swdr_pkg::WidthReset;
      last_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q     <= 1'b1;
        cnt_q      <= '0;
        carry_q    <= 1'b0;
        wsel_q     <= q_data_i.wsel;
        last_idx_q <= q_data_i.last_idx;
      end else if (adv) begin
        if (is_last) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q   <= cnt_q + swdr_pkg::IdxBits'(1);
          carry_q <= carry_nx;
        end
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sh_q <= q_data_i.scalar;
    end else if (adv) begin
      sh_q <= sh_nx;
    end
    if (adv) begin
      out_q.window_index    <= cnt_q;
      out_q.digit_negative  <= neg;
      out_q.digit_magnitude <= mag;
      out_q.last_digit      <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_top_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.last_digit |-> !out_q.digit_negative)
    else $error("top window digit negative");

  a_neg_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.digit_negative |-> out_q.digit_magnitude != '0)
    else $error("negative digit with zero magnitude");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= last_idx_q)
    else $error("window counter past top window");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !adv |=> busy_q && cnt_q == $past(cnt_q))
    else $error("window advanced while output stalled");

endmodule

// ----- hdl/signed_window_digit_recoder_core.sv -----
// An accepted scalar is queued, loaded into the back-end shift register, then recoded
// into the output register. One digit beat per cycle unless the output stalls; a scalar
// gives 8 to 13 digits, one per window (13 at 10-bit), from the single window walker.
// A 2-entry queue lets the next scalar be taken while the current one is still walked.
// Reset (async, active low) empties queue and output, window_width returns to 16.
module signed_window_digit_recoder_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  swdr_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output swdr_pkg::out_t out_data_o
);

  logic           push, q_ready, q_valid, pop;
  swdr_pkg::job_t push_data, pop_data;

  swdr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .q_ready_i   (q_ready)
  );

  swdr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  swdr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/swdr_digit_checker.sv -----
// Digit checker: tracks window_width, predicts the signed digits of each scalar, compares beats.
`timescale 1ns / 100ps

module swdr_digit_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  input  logic [31:0]    prdata,
  input  logic           pready,
  input  logic           in_valid_i,
  input  logic           in_ready_o,
  input  swdr_pkg::in_t  in_data_i,
  input  logic           out_valid_o,
  input  logic           out_ready_i,
  input  swdr_pkg::out_t out_data_o,
  output int             fail_count_o,
  output int             digits_pending_o,
  output int             digits_checked_o
);

  localparam logic [2:0] AddrWidthReg = {swdr_pkg::RegWindowWidth, 2'b00};

  logic [swdr_pkg::WidthBits-1:0] width_q;
  swdr_pkg::out_t                 digits_q[$];

  // Expand one scalar into its signed digits, lowest window first
  function automatic void recode_scalar(logic [swdr_pkg::ScalarBits-1:0] s,
                                        logic [swdr_pkg::WidthBits-1:0]  req);
    int unsigned                     w;
    int unsigned                     count;
    int unsigned                     pos;
    int unsigned                     len;
    logic [swdr_pkg::ScalarBits-1:0] shifted;
    logic [swdr_pkg::MagBits-1:0]    v;
    logic [swdr_pkg::MagBits-1:0]    half;
    logic [swdr_pkg::MagBits-1:0]    full;
    logic [swdr_pkg::MagBits-1:0]    mask;
    logic                            carry;
    logic                            is_top;
    swdr_pkg::out_t                  d;
    if (req <= 10) w = 10;
    else if (req == 14) w = 13;
    else if (req > 16) w = 16;
    else w = req;
    count = (swdr_pkg::ScalarBits + w - 1) / w;
    full  = 17'(1) << w;
    half  = 17'(1) << (w - 1);
    carry = 1'b0;
    for (int unsigned k = 0; k < count; k++) begin
      pos     = k * w;
      is_top  = (k + 1 == count);
      len     = is_top ? swdr_pkg::ScalarBits - pos : w;
      mask    = (17'(1) << len) - 17'(1);
      shifted = s >> pos;
      v       = (shifted[swdr_pkg::MagBits-1:0] & mask) + 17'(carry);
      d.window_index    = 4'(k);
      d.last_digit      = is_top;
      d.digit_negative  = 1'b0;
      d.digit_magnitude = v;
      carry = 1'b0;
      // above half: borrow 2^W from the next window; exactly 2^W gives a zero digit
      if (!is_top && v > half) begin
        carry = 1'b1;
        if (v == full) begin
          d.digit_magnitude = '0;
        end else begin
          d.digit_negative  = 1'b1;
          d.digit_magnitude = full - v;
        end
      end
      digits_q.push_back(d);
    end
  endfunction

  initial begin
    fail_count_o     = 0;
    digits_pending_o = 0;
    digits_checked_o = 0;
    width_q          = swdr_pkg::WidthReset;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    swdr_pkg::out_t exp_d;
    if (!rst_ni) begin
      width_q = swdr_pkg::WidthReset;
      digits_q.delete();
    end else begin
      if (psel && penable && pready && paddr == AddrWidthReg) begin
        if (pwrite) begin
          width_q = pwdata[swdr_pkg::WidthBits-1:0];
        end else if (prdata != 32'(width_q)) begin
          $error("window_width readback: expected %0d, got %0d", width_q, prdata);
          fail_count_o++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        recode_scalar({in_data_i.scalar_high, in_data_i.scalar_low}, width_q);
      end
      if (out_valid_o && out_ready_i) begin
        if (digits_q.size() == 0) begin
          $error("digit beat with nothing expected: index %0d mag %0d",
                 out_data_o.window_index, out_data_o.digit_magnitude);
          fail_count_o++;
        end else begin
          exp_d = digits_q.pop_front();
          digits_checked_o++;
          if (out_data_o.window_index != exp_d.window_index) begin
            $error("window_index: expected %0d, got %0d",
                   exp_d.window_index, out_data_o.window_index);
            fail_count_o++;
          end
          if (out_data_o.digit_negative != exp_d.digit_negative) begin
            $error("digit_negative: expected %0d, got %0d",
                   exp_d.digit_negative, out_data_o.digit_negative);
            fail_count_o++;
          end
          if (out_data_o.digit_magnitude != exp_d.digit_magnitude) begin
            $error("digit_magnitude: expected %0d, got %0d",
                   exp_d.digit_magnitude, out_data_o.digit_magnitude);
            fail_count_o++;
          end
          if (out_data_o.last_digit != exp_d.last_digit) begin
            $error("last_digit: expected %0d, got %0d",
                   exp_d.last_digit, out_data_o.last_digit);
            fail_count_o++;
          end
        end
      end
    end
    digits_pending_o = digits_q.size();
  end

endmodule

// ----- tb/tb_signed_window_digit_recoder_core.sv -----
// Testbench top: clock, reset, scalar and width stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb_signed_window_digit_recoder_core;

  localparam logic [2:0] AddrWidthReg  = {swdr_pkg::RegWindowWidth, 2'b00};
  localparam logic [2:0] AddrUnusedReg = 3'd4;
  localparam int         NumSettings   = 10;
  localparam int         RandPerPhase  = 50;
  localparam int         GapCap        = 20;
  localparam int         QuietLimit    = 5000;

  typedef enum int {
    WinBelowHalf, WinHalf, WinAboveHalf, WinAllOnes, WinZero, WinRandom, WinMixed
  } win_pick_e;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           psel        = 1'b0;
  logic           penable     = 1'b0;
  logic           pwrite      = 1'b0;
  logic [2:0]     paddr       = '0;
  logic [31:0]    pwdata      = '0;
  logic [31:0]    prdata;
  logic           pready;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  swdr_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  swdr_pkg::out_t out_data_o;

  int fail_count;
  int digits_pending;
  int digits_checked;
  int scalars_sent   = 0;
  int sender_gap_pct = 33;
  int recv_stall_pct = 50;
  int quiet_cycles   = 0;

  // requested width and the slicing it selects; 3, 31 and 0 fall outside 10..16
  int unsigned req_tbl[NumSettings] = '{10, 11, 12, 13, 14, 15, 16, 3, 31, 0};
  int unsigned eff_tbl[NumSettings] = '{10, 11, 12, 13, 13, 15, 16, 10, 16, 10};

  signed_window_digit_recoder_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  swdr_digit_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_data_i       (in_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_o      (out_data_o),
    .fail_count_o    (fail_count),
    .digits_pending_o(digits_pending),
    .digits_checked_o(digits_checked)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // no beat on either channel for too long means the block hung
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("[signed_window_digit_recoder_core] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [swdr_pkg::ScalarBits-1:0] rand_wide();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // Fill every w-bit window: near the digit thresholds, zero, all ones or random
  function automatic logic [swdr_pkg::ScalarBits-1:0] tile_windows(int unsigned w,
                                                                   win_pick_e   pick);
    logic [swdr_pkg::ScalarBits-1:0] s;
    logic [swdr_pkg::MagBits-1:0]    v;
    logic [swdr_pkg::MagBits-1:0]    mask;
    win_pick_e                       p;
    s    = '0;
    mask = (17'(1) << w) - 17'(1);
    for (int unsigned pos = 0; pos < swdr_pkg::ScalarBits; pos += w) begin
      p = (pick == WinMixed) ? win_pick_e'($urandom_range(5)) : pick;
      case (p)
        WinBelowHalf: v = (17'(1) << (w - 1)) - 17'(1);
        WinHalf:      v = 17'(1) << (w - 1);
        WinAboveHalf: v = (17'(1) << (w - 1)) + 17'(1);
        WinAllOnes:   v = mask;
        WinZero:      v = '0;
        default:      v = 17'($urandom());
      endcase
      s |= swdr_pkg::ScalarBits'(v & mask) << pos;
    end
    return s;
  endfunction

  function automatic logic [swdr_pkg::ScalarBits-1:0] random_scalar(int unsigned w);
    logic [swdr_pkg::ScalarBits-1:0] s;
    case ($urandom_range(4))
      0: s = rand_wide();
      1, 2: s = tile_windows(w, WinMixed);
      3: begin
        for (int i = 0; i < swdr_pkg::ScalarBits / 8; i++) begin
          case ($urandom_range(2))
            0:       s[i*8 +: 8] = 8'h00;
            1:       s[i*8 +: 8] = 8'hFF;
            default: s[i*8 +: 8] = 8'($urandom());
          endcase
        end
      end
      default: begin
        s = rand_wide() & rand_wide() & rand_wide();
        if ($urandom_range(1)) s = ~s;
      end
    endcase
    return s;
  endfunction

  task automatic push_scalar(logic [swdr_pkg::ScalarBits-1:0] s);
    int gap;
    gap = 0;
    // idle split: sender 33 / receiver 50, then 50 / 33, then none
    if (scalars_sent < 173) begin
      sender_gap_pct = 33;
      recv_stall_pct = 50;
    end else if (scalars_sent < 346) begin
      sender_gap_pct = 50;
      recv_stall_pct = 33;
    end else begin
      sender_gap_pct = 0;
      recv_stall_pct = 0;
    end
    while (gap < GapCap && $urandom_range(99) < sender_gap_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{scalar_low:  s[swdr_pkg::HalfBits-1:0],
                    scalar_high: s[swdr_pkg::ScalarBits-1:swdr_pkg::HalfBits]};
    do @(posedge clk_i); while (!in_ready_o);
    scalars_sent++;
  endtask

  task automatic apb_xfer(logic [2:0] addr, logic wr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      #1;
    end while (digits_pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset width is 16
    apb_xfer(AddrWidthReg, 1'b0, '0);
    push_scalar('0);
    push_scalar({swdr_pkg::ScalarBits{1'b1}});
    push_scalar({{swdr_pkg::HalfBits{1'b0}}, {swdr_pkg::HalfBits{1'b1}}});
    push_scalar({{swdr_pkg::HalfBits{1'b1}}, {swdr_pkg::HalfBits{1'b0}}});
    push_scalar(tile_windows(16, WinHalf));
    push_scalar(tile_windows(16, WinAboveHalf));
    push_scalar(tile_windows(16, WinBelowHalf));
    push_scalar(swdr_pkg::ScalarBits'(1));
    push_scalar({1'b1, {(swdr_pkg::ScalarBits-1){1'b0}}});
    push_scalar({(swdr_pkg::ScalarBits/4){4'h5}} ^ tile_windows(16, WinZero));

    for (int p = 0; p < NumSettings; p++) begin
      wait_drained();
      // upper data bits are junk on purpose
      apb_xfer(AddrWidthReg, 1'b1, ($urandom() & ~32'h1F) | req_tbl[p]);
      if (p == 3) apb_xfer(AddrUnusedReg, 1'b1, 32'(swdr_pkg::WidthW16));
      apb_xfer(AddrWidthReg, 1'b0, '0);
      push_scalar(tile_windows(eff_tbl[p], WinHalf));
      for (int i = 0; i < RandPerPhase; i++) begin
        push_scalar(random_scalar(eff_tbl[p]));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Recoded %0d scalars under the reset width and %0d written widths", scalars_sent,
             NumSettings);
    $display("(10..16, below and above range), %0d digit beats compared", digits_checked);
    if (fail_count == 0 && digits_pending == 0) begin
      $display("[signed_window_digit_recoder_core] OK");
    end else begin
      $display("[signed_window_digit_recoder_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/swdr_pkg.sv
hdl/swdr_front.sv
hdl/swdr_queue.sv
hdl/swdr_back.sv
hdl/signed_window_digit_recoder_core.sv
tb/swdr_digit_checker.sv
tb/tb_signed_window_digit_recoder_core.sv
